FILE: hw/rtl/ppal_pkg.sv
// ppal_pkg: shared types, codes and defaults of the per-peer admission limiter
// used by ppal_cell, ppal_rem and per_peer_admission_limiter_top; no dependencies
package ppal_pkg;

   localparam int PEER_SLOTS_DEFAULT     = 16;
   localparam int PERIOD_SECONDS_DEFAULT = 3600;

   localparam logic [2:0] OP_ADMIT  = 3'd0;
   localparam logic [2:0] OP_SETTLE = 3'd1;
   localparam logic [2:0] OP_REFILL = 3'd2;
   localparam logic [2:0] OP_QUERY  = 3'd3;
   localparam logic [2:0] OP_SETLIM = 3'd4;

   localparam logic [2:0] RSN_NONE   = 3'd0;
   localparam logic [2:0] RSN_MISS   = 3'd1;
   localparam logic [2:0] RSN_COUNT  = 3'd2;
   localparam logic [2:0] RSN_AMOUNT = 3'd3;
   localparam logic [2:0] RSN_TOKENS = 3'd4;

   localparam logic [2:0] CSR_COUNT_LIMIT  = 3'd0;
   localparam logic [2:0] CSR_AMOUNT_LIMIT = 3'd1;
   localparam logic [2:0] CSR_RATE         = 3'd2;
   localparam logic [2:0] CSR_BAN_ENABLE   = 3'd3;
   localparam logic [2:0] CSR_BAN_DURATION = 3'd4;

   localparam logic [15:0] DEF_COUNT_LIMIT  = 16'd483;
   localparam logic [60:0] DEF_AMOUNT_LIMIT = 61'd5000000000;
   localparam logic [23:0] DEF_RATE         = 24'd3600;

   typedef enum logic [1:0] {
      MODE_LOOKUP = 2'd0,
      MODE_WRITE  = 2'd1,
      MODE_REFILL = 2'd2
   } mode_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [63:0] peer_tag;
      logic [60:0] amount;
      logic [31:0] time_now;
      logic [15:0] new_count_limit;
      logic [60:0] new_amount_limit;
      logic [23:0] new_hourly_rate;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [2:0]  reason;
      logic        ban_request;
      logic [31:0] ban_seconds;
      logic [15:0] pending_items;
      logic [63:0] pending_amount;
   } rsp_type;

   typedef struct packed {
      logic [63:0] tag;
      logic [15:0] count_limit;
      logic [60:0] amount_limit;
      logic [23:0] rate;
      logic [23:0] tokens;
      logic [31:0] refill_time;
      logic [15:0] pending_items;
      logic [63:0] pending_amount;
   } entry_type;

   typedef struct packed {
      logic        act;
      mode_type    mode;
      logic [63:0] tag;
      logic [31:0] now;
      logic        found;
      entry_type   ent;
   } tok_type;

endpackage

FILE: hw/rtl/per_peer_admission_limiter_top.sv
// per_peer_admission_limiter_top: token-bucket admission limiter kept per peer
// depends on ppal_pkg, ppal_cell and ppal_rem
//
// One request is worked on at a time. Its token runs through a row of PEER_SLOTS
// cells, one cell per cycle, to find the peer; a change is carried back by a
// second pass. Query and misses use the lookup pass alone, refill all one pass, and
// an unknown opcode goes straight to the result; settle, set limits and admit add
// the write pass, admit after the limit check. Admit and set limits first take a
// free slot when the peer is new, and an admit whose peer is due for refill first
// takes the remainder by the period. A result waits while the output holds one not yet taken.
// A finished result waits in the output register while the next request is taken.
module per_peer_admission_limiter_top
   import ppal_pkg::*;
#(
   parameter int PEER_SLOTS     = PEER_SLOTS_DEFAULT,
   parameter int PERIOD_SECONDS = PERIOD_SECONDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int IW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
   localparam int UW = $clog2(PEER_SLOTS + 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SEND  = 7'b0000010,
      S_WAIT  = 7'b0000100,
      S_EVAL  = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_CHECK = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   mode_type      mode_ff, mode_in;
   entry_type     ent_ff, ent_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          found_ff, found_in;
   logic [UW-1:0] used_ff, used_in;
   rsp_type       res_ff, res_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   cfg_count_ff, cfg_count_in;
   logic [60:0]   cfg_amount_ff, cfg_amount_in;
   logic [23:0]   cfg_rate_ff, cfg_rate_in;
   logic          cfg_ban_ff, cfg_ban_in;
   logic [31:0]   cfg_ban_s_ff, cfg_ban_s_in;

   tok_type       tok [0:PEER_SLOTS];
   logic [IW-1:0] idx [0:PEER_SLOTS];

   logic          div_start;
   logic          div_done;
   logic [31:0]   div_rem;
   logic          due;
   logic [64:0]   sum_raw;
   logic [63:0]   sum_sat;

   assign tok[0].act   = (state_ff == S_SEND);
   assign tok[0].mode  = mode_ff;
   assign tok[0].tag   = req_ff.peer_tag;
   assign tok[0].now   = req_ff.time_now;
   assign tok[0].found = 1'b0;
   assign tok[0].ent   = ent_ff;
   assign idx[0]       = idx_ff;

   for (genvar g = 0; g < PEER_SLOTS; g++) begin : g_cell
      ppal_cell #(
         .PEER_SLOTS     (PEER_SLOTS),
         .PERIOD_SECONDS (PERIOD_SECONDS),
         .CELL_IDX       (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .used_in (used_ff),
         .tok_in  (tok[g]),
         .idx_in  (idx[g]),
         .tok_out (tok[g+1]),
         .idx_out (idx[g+1])
      );
   end

   ppal_rem #(
      .PERIOD_SECONDS (PERIOD_SECONDS)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_ff.time_now - ent_ff.refill_time),
      .done     (div_done),
      .rem      (div_rem)
   );

   assign due     = {1'b0, req_ff.time_now} >=
                    ({1'b0, ent_ff.refill_time} + 33'(PERIOD_SECONDS));
   assign sum_raw = {1'b0, ent_ff.pending_amount} + {4'b0, req_ff.amount};
   assign sum_sat = sum_raw[64] ? '1 : sum_raw[63:0];

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      mode_in       = mode_ff;
      ent_in        = ent_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      used_in       = used_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      cfg_count_in  = cfg_count_ff;
      cfg_amount_in = cfg_amount_ff;
      cfg_rate_in   = cfg_rate_ff;
      cfg_ban_in    = cfg_ban_ff;
      cfg_ban_s_in  = cfg_ban_s_ff;
      div_start     = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_COUNT_LIMIT:  cfg_count_in  = csr_data[15:0];
            CSR_AMOUNT_LIMIT: cfg_amount_in = csr_data[60:0];
            CSR_RATE:         cfg_rate_in   = csr_data[23:0];
            CSR_BAN_ENABLE:   cfg_ban_in    = csr_data[0];
            CSR_BAN_DURATION: cfg_ban_s_in  = csr_data[31:0];
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               res_in   = '0;
               found_in = 1'b0;
               if (req_data.opcode == OP_REFILL) begin
                  mode_in  = MODE_REFILL;
                  state_in = S_SEND;
               end else if (req_data.opcode inside {OP_ADMIT, OP_SETTLE, OP_QUERY,
                                                    OP_SETLIM}) begin
                  mode_in  = MODE_LOOKUP;
                  state_in = S_SEND;
               end else begin
                  res_in.reason = RSN_MISS;
                  state_in      = S_DONE;
               end
            end
         end
         S_SEND: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (tok[PEER_SLOTS].act) begin
               case (mode_ff)
                  MODE_LOOKUP: begin
                     found_in = tok[PEER_SLOTS].found;
                     ent_in   = tok[PEER_SLOTS].ent;
                     idx_in   = idx[PEER_SLOTS];
                     state_in = S_EVAL;
                  end
                  MODE_REFILL: begin
                     res_in.ok = 1'b1;
                     state_in  = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_EVAL: begin
            if (!found_ff) begin
               if ((req_ff.opcode == OP_ADMIT || req_ff.opcode == OP_SETLIM) &&
                   used_ff < UW'(PEER_SLOTS)) begin
                  ent_in.tag            = req_ff.peer_tag;
                  ent_in.count_limit    = cfg_count_ff;
                  ent_in.amount_limit   = cfg_amount_ff;
                  ent_in.rate           = cfg_rate_ff;
                  ent_in.tokens         = cfg_rate_ff;
                  ent_in.refill_time    = '0;
                  ent_in.pending_items  = '0;
                  ent_in.pending_amount = '0;
                  idx_in                = used_ff[IW-1:0];
                  used_in               = used_ff + UW'(1);
                  found_in              = 1'b1;
               end else begin
                  res_in.reason = RSN_MISS;
                  state_in      = S_DONE;
               end
            end else begin
               case (req_ff.opcode)
                  OP_QUERY: begin
                     res_in.ok             = 1'b1;
                     res_in.pending_items  = ent_ff.pending_items;
                     res_in.pending_amount = ent_ff.pending_amount;
                     state_in              = S_DONE;
                  end
                  OP_SETTLE: begin
                     if (ent_ff.pending_items != '0) begin
                        ent_in.pending_items = ent_ff.pending_items - 16'd1;
                     end
                     ent_in.pending_amount =
                        (ent_ff.pending_amount >= {3'b0, req_ff.amount}) ?
                        ent_ff.pending_amount - {3'b0, req_ff.amount} : '0;
                     res_in.ok = 1'b1;
                     mode_in   = MODE_WRITE;
                     state_in  = S_SEND;
                  end
                  OP_SETLIM: begin
                     ent_in.count_limit  = req_ff.new_count_limit;
                     ent_in.amount_limit = req_ff.new_amount_limit;
                     ent_in.rate         = req_ff.new_hourly_rate;
                     if (ent_ff.tokens > req_ff.new_hourly_rate) begin
                        ent_in.tokens = req_ff.new_hourly_rate;
                     end
                     res_in.ok = 1'b1;
                     mode_in   = MODE_WRITE;
                     state_in  = S_SEND;
                  end
                  default: begin
                     if (due) begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end else begin
                        state_in = S_CHECK;
                     end
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (ent_ff.rate != '0) begin
                  ent_in.tokens = ent_ff.rate;
               end
               ent_in.refill_time = req_ff.time_now - div_rem;
               state_in           = S_CHECK;
            end
         end
         S_CHECK: begin
            if (ent_ff.pending_items >= ent_ff.count_limit) begin
               res_in.reason = RSN_COUNT;
            end else if (ent_ff.amount_limit != '0 &&
                         sum_sat > {3'b0, ent_ff.amount_limit}) begin
               res_in.reason = RSN_AMOUNT;
            end else if (ent_ff.tokens == '0) begin
               res_in.reason = RSN_TOKENS;
               if (cfg_ban_ff) begin
                  res_in.ban_request = 1'b1;
                  res_in.ban_seconds = cfg_ban_s_ff;
               end
            end else begin
               ent_in.tokens         = ent_ff.tokens - 24'd1;
               ent_in.pending_items  = ent_ff.pending_items + 16'd1;
               ent_in.pending_amount = sum_sat;
               res_in.ok             = 1'b1;
            end
            mode_in  = MODE_WRITE;
            state_in = S_SEND;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         cfg_count_ff  <= DEF_COUNT_LIMIT;
         cfg_amount_ff <= DEF_AMOUNT_LIMIT;
         cfg_rate_ff   <= DEF_RATE;
         cfg_ban_ff    <= 1'b0;
         cfg_ban_s_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         rsp_valid_ff  <= rsp_valid_in;
         cfg_count_ff  <= cfg_count_in;
         cfg_amount_ff <= cfg_amount_in;
         cfg_rate_ff   <= cfg_rate_in;
         cfg_ban_ff    <= cfg_ban_in;
         cfg_ban_s_ff  <= cfg_ban_s_in;
      end
      req_ff   <= req_in;
      mode_ff  <= mode_in;
      ent_ff   <= ent_in;
      idx_ff   <= idx_in;
      found_ff <= found_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   a_tail_in_wait: assert property (@(posedge clock) disable iff (reset)
      tok[PEER_SLOTS].act |-> state_ff == S_WAIT)
      else $error("token left the chain outside of a pass");

   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("remainder finished outside of refill");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(PEER_SLOTS))
      else $error("slot count beyond table size");

   a_ok_reason: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.ok) |-> rsp_data.reason == RSN_NONE)
      else $error("accepted result carries a reason");

endmodule

FILE: hw/rtl/ppal_cell.sv
// ppal_cell: one peer slot of the chain; holds an entry and passes the token on
// depends on ppal_pkg
module ppal_cell
   import ppal_pkg::*;
#(
   parameter int PEER_SLOTS     = PEER_SLOTS_DEFAULT,
   parameter int PERIOD_SECONDS = PERIOD_SECONDS_DEFAULT,
   parameter int CELL_IDX       = 0,
   localparam int IW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1,
   localparam int UW = $clog2(PEER_SLOTS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [UW-1:0] used_in,
   input  tok_type       tok_in,
   input  logic [IW-1:0] idx_in,
   output tok_type       tok_out,
   output logic [IW-1:0] idx_out
);

   entry_type     ent_ff, ent_in;
   tok_type       tok_ff, tok_nx;
   logic [IW-1:0] idx_ff, idx_nx;
   logic          live;
   logic          due;

   assign live = used_in > UW'(CELL_IDX);
   assign due  = {1'b0, tok_in.now} >= ({1'b0, ent_ff.refill_time} + 33'(PERIOD_SECONDS));

   always_comb begin
      tok_nx = tok_in;
      idx_nx = idx_in;
      ent_in = ent_ff;
      if (tok_in.act) begin
         case (tok_in.mode)
            MODE_LOOKUP: begin
               if (live && !tok_in.found && ent_ff.tag == tok_in.tag) begin
                  tok_nx.found = 1'b1;
                  tok_nx.ent   = ent_ff;
                  idx_nx       = IW'(CELL_IDX);
               end
            end
            MODE_WRITE: begin
               if (idx_in == IW'(CELL_IDX)) begin
                  ent_in = tok_in.ent;
               end
            end
            MODE_REFILL: begin
               if (live && due) begin
                  ent_in.tokens      = ent_ff.rate;
                  ent_in.refill_time = tok_in.now;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      idx_ff <= idx_nx;
      if (reset) begin
         tok_ff.act <= 1'b0;
      end else begin
         tok_ff <= tok_nx;
      end
   end

   assign tok_out = tok_ff;
   assign idx_out = idx_ff;

endmodule

FILE: hw/rtl/ppal_rem.sv
// ppal_rem: remainder of a 32-bit elapsed time by the refill period
// reciprocal multiply, registered as operand, product and remainder; depends on ppal_pkg
module ppal_rem
   import ppal_pkg::*;
#(
   parameter int PERIOD_SECONDS = PERIOD_SECONDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   output logic        done,
   output logic [31:0] rem
);

   localparam int          SH         = 32 + $clog2(PERIOD_SECONDS);
   localparam logic [63:0] MAGIC_WIDE =
      ((64'd1 << SH) + 64'(PERIOD_SECONDS) - 64'd1) / 64'(PERIOD_SECONDS);
   localparam logic [32:0] MAGIC      = MAGIC_WIDE[32:0];

   logic [31:0] x_ff, x_in;
   logic [64:0] prod_ff, prod_in;
   logic [31:0] rem_ff, rem_in;
   logic        mul_vld_ff, mul_vld_in;
   logic        sub_vld_ff, sub_vld_in;
   logic        done_ff, done_in;
   logic [31:0] quo;

   // quotient is exact for every 32-bit dividend with the rounded-up reciprocal
   assign quo = 32'(prod_ff >> SH);

   always_comb begin
      x_in       = start ? dividend : x_ff;
      mul_vld_in = start;
      prod_in    = 65'(x_ff) * 65'(MAGIC);
      sub_vld_in = mul_vld_ff;
      rem_in     = x_ff - quo * 32'(PERIOD_SECONDS);
      done_in    = sub_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         sub_vld_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         mul_vld_ff <= mul_vld_in;
         sub_vld_ff <= sub_vld_in;
         done_ff    <= done_in;
      end
      x_ff    <= x_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule
